// File: rtl/lstp_pkg.sv
package lstp_pkg;

  localparam int RANGE_BITS_DEF = 16;
  localparam int ANGLE_BITS_DEF = 16;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int OUT_W     = 18;

  localparam int CORDIC_STEPS = 16;
  localparam int ITER_W       = $clog2(CORDIC_STEPS);
  localparam int GAIN_W       = 16;
  localparam logic [GAIN_W-1:0] CORDIC_GAIN = 16'd39797;

  // atan(2^-i) in a 2^32-per-turn phase
  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_ANGLE = 3'd0,
    REG_ANGLE_STEP  = 3'd1,
    REG_MOUNT_X     = 3'd2,
    REG_MOUNT_Y     = 3'd3,
    REG_MIRROR_X    = 3'd4,
    REG_MASK_RADIUS = 3'd5,
    REG_MASK_CX     = 3'd6,
    REG_MASK_CY     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic        [15:0] start_angle;
    logic signed [15:0] angle_step;
    logic signed [15:0] mount_x;
    logic signed [15:0] mount_y;
    logic               mirror_x;
    logic        [15:0] mask_radius;
    logic signed [15:0] mask_cx;
    logic signed [15:0] mask_cy;
  } cfg_t;

endpackage

// File: rtl/lstp_ifs.sv
interface lstp_in_if #(
  parameter int RANGE_BITS = lstp_pkg::RANGE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [RANGE_BITS-1:0] range_mm;
  logic                  range_ok;
  logic                  scan_first;

  modport source (output valid, range_mm, range_ok, scan_first, input ready);
  modport sink   (input valid, range_mm, range_ok, scan_first, output ready);
endinterface

interface lstp_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [lstp_pkg::OUT_W-1:0] point_x;
  logic signed [lstp_pkg::OUT_W-1:0] point_y;

  modport source (output valid, point_x, point_y, input ready);
  modport sink   (input valid, point_x, point_y, output ready);
endinterface

// File: rtl/lidar_scan_to_points_mask.sv
// The back end takes one queued sample at a time through the multiply, the
// 16-step iterative CORDIC and the offset, square and compare steps, and it
// waits in the compare step while a kept point is stalled at the output;
// skipped samples only advance the angle in the front end, which keeps accepting
// while the back end works, up to a two-entry request queue.
// Reset (rst, synchronous): clears registers, beam angle, queue and output.
module lidar_scan_to_points_mask #(
  parameter int RANGE_BITS = lstp_pkg::RANGE_BITS_DEF,
  parameter int ANGLE_BITS = lstp_pkg::ANGLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          write_en,
  input  logic [lstp_pkg::CFG_IDX_W-1:0] write_index,
  input  logic [lstp_pkg::CFG_W-1:0]    write_data,
  lstp_in_if.sink                       samples,
  lstp_out_if.source                    points
);

  localparam int QW = RANGE_BITS + ANGLE_BITS;

  lstp_pkg::cfg_t cfg;
  logic           q_push;
  logic [QW-1:0]  q_wdata;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;
  logic [QW-1:0]  q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (write_en) begin
      unique case (lstp_pkg::reg_idx_t'(write_index))
        lstp_pkg::REG_START_ANGLE: cfg.start_angle <= write_data;
        lstp_pkg::REG_ANGLE_STEP:  cfg.angle_step  <= signed'(write_data);
        lstp_pkg::REG_MOUNT_X:     cfg.mount_x     <= signed'(write_data);
        lstp_pkg::REG_MOUNT_Y:     cfg.mount_y     <= signed'(write_data);
        lstp_pkg::REG_MIRROR_X:    cfg.mirror_x    <= write_data[0];
        lstp_pkg::REG_MASK_RADIUS: cfg.mask_radius <= write_data;
        lstp_pkg::REG_MASK_CX:     cfg.mask_cx     <= signed'(write_data);
        lstp_pkg::REG_MASK_CY:     cfg.mask_cy     <= signed'(write_data);
        default: cfg <= cfg;
      endcase
    end
  end

  lstp_front #(
    .RANGE_BITS (RANGE_BITS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .cfg     (cfg),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  lstp_queue #(
    .W (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_rdata)
  );

  lstp_back #(
    .RANGE_BITS (RANGE_BITS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .points  (points)
  );

endmodule

// File: rtl/lstp_queue.sv
module lstp_queue #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign full     = (count == 2'd2);
  assign valid    = (count != 2'd0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/lstp_front.sv
module lstp_front #(
  parameter int RANGE_BITS = lstp_pkg::RANGE_BITS_DEF,
  parameter int ANGLE_BITS = lstp_pkg::ANGLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  lstp_in_if.sink                          samples,
  input  lstp_pkg::cfg_t                   cfg,
  input  logic                             q_full,
  output logic                             q_push,
  output logic [RANGE_BITS+ANGLE_BITS-1:0] q_data
);

  logic [ANGLE_BITS-1:0]    beam_angle;
  logic [ANGLE_BITS+15:0]   start_wide;
  logic [ANGLE_BITS+15:0]   step_wide;
  logic [ANGLE_BITS-1:0]    start_a;
  logic [ANGLE_BITS-1:0]    step_a;
  logic [ANGLE_BITS-1:0]    ang_sel;
  logic                     accept;

  // start angle is taken modulo the turn, the step is sign-extended
  assign start_wide = {{ANGLE_BITS{1'b0}}, cfg.start_angle};
  assign step_wide  = {{ANGLE_BITS{cfg.angle_step[15]}}, cfg.angle_step};
  assign start_a    = start_wide[ANGLE_BITS-1:0];
  assign step_a     = step_wide[ANGLE_BITS-1:0];

  assign samples.ready = ~q_full;
  assign accept        = samples.valid & ~q_full;
  assign ang_sel       = samples.scan_first ? start_a : beam_angle;

  // skipped samples only advance the angle
  assign q_push = accept & samples.range_ok;
  assign q_data = {samples.range_mm, ang_sel};

  always_ff @(posedge clk) begin
    if (rst) begin
      beam_angle <= '0;
    end else if (accept) begin
      beam_angle <= ang_sel + step_a;
    end
  end

endmodule

// File: rtl/lstp_back.sv
module lstp_back #(
  parameter int RANGE_BITS = lstp_pkg::RANGE_BITS_DEF,
  parameter int ANGLE_BITS = lstp_pkg::ANGLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  lstp_pkg::cfg_t                   cfg,
  input  logic                             q_valid,
  input  logic [RANGE_BITS+ANGLE_BITS-1:0] q_data,
  output logic                             q_pop,
  lstp_out_if.source                       points
);

  localparam int XW  = RANGE_BITS + 19;                      // CORDIC datapath
  localparam int RW  = XW - 16;                              // after rounding
  localparam int PW  = ((RANGE_BITS > 16) ? RANGE_BITS : 16) + 3;
  localparam int DW  = PW + 1;                               // distance to centre
  localparam int QW  = 2 * DW;                               // squared distance
  localparam int SW  = (QW + 1 > 33) ? QW + 1 : 33;
  localparam int ZW  = 34;
  localparam int OW  = lstp_pkg::OUT_W;
  localparam int EW  = (PW > OW) ? PW : OW;
  localparam int IW  = lstp_pkg::ITER_W;
  localparam int MW  = RANGE_BITS + 16;                      // range times gain

  localparam logic signed [ZW-1:0] QUARTER = 34'sd1073741824;
  localparam logic signed [ZW-1:0] HALF    = 34'sd2147483648;
  localparam logic signed [XW-1:0] RND     = XW'(32768);
  localparam logic signed [EW-1:0] OMAX    = EW'((1 << (OW - 1)) - 1);
  localparam logic signed [EW-1:0] OMIN    = -EW'(1 << (OW - 1));

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_ITER, S_OFFS, S_SQR, S_TEST} state_t;

  state_t                    state;
  logic [RANGE_BITS-1:0]     r_reg;
  logic [ANGLE_BITS-1:0]     ang_reg;
  logic signed [XW-1:0]      x;
  logic signed [XW-1:0]      y;
  logic signed [ZW-1:0]      z;
  logic                      flip;
  logic [IW-1:0]             iter;
  logic signed [PW-1:0]      px;
  logic signed [PW-1:0]      py;
  logic [QW-1:0]             sqx;
  logic [QW-1:0]             sqy;
  logic [31:0]               rsq;
  logic                      out_valid;
  logic signed [OW-1:0]      out_x;
  logic signed [OW-1:0]      out_y;

  logic [31:0]               phase;
  logic signed [31:0]        z32;
  logic signed [ZW-1:0]      zs;
  logic signed [ZW-1:0]      z_fold;
  logic                      flip_c;
  logic [MW-1:0]             prod;
  logic signed [XW-1:0]      sx;
  logic signed [XW-1:0]      sy;
  logic signed [ZW-1:0]      atan;
  logic signed [XW-1:0]      xn;
  logic signed [XW-1:0]      yn;
  logic signed [XW-1:0]      xrf;
  logic signed [XW-1:0]      yrf;
  logic signed [RW-1:0]      xr;
  logic signed [RW-1:0]      yr;
  logic signed [PW-1:0]      px_off;
  logic signed [PW-1:0]      py_off;
  logic signed [DW-1:0]      ddx;
  logic signed [DW-1:0]      ddy;
  logic signed [QW-1:0]      sqx_c;
  logic signed [QW-1:0]      sqy_c;
  logic [SW-1:0]             dist_sq;
  logic                      keep;
  logic                      out_free;
  logic signed [EW-1:0]      pxe;
  logic signed [EW-1:0]      pye;
  logic signed [EW-1:0]      pxs;
  logic signed [EW-1:0]      pys;

  assign q_pop = (state == S_IDLE) & q_valid;

  // fold the phase into +-90 degrees; a fold negates both results
  assign phase = {ang_reg, {(32 - ANGLE_BITS){1'b0}}};
  assign z32   = signed'(phase);
  assign zs    = ZW'(z32);
  always_comb begin
    z_fold = zs;
    flip_c = 1'b0;
    if (zs > QUARTER) begin
      z_fold = zs - HALF;
      flip_c = 1'b1;
    end else if (zs < -QUARTER) begin
      z_fold = zs + HALF;
      flip_c = 1'b1;
    end
  end
  assign prod = MW'(r_reg) * MW'(lstp_pkg::CORDIC_GAIN);

  // one rotation step per cycle
  assign sx   = x >>> iter;
  assign sy   = y >>> iter;
  assign atan = ZW'(lstp_pkg::ATAN_TAB[iter]);

  // round half up, add mount offset, optional mirror
  assign xn     = flip ? -x : x;
  assign yn     = flip ? -y : y;
  assign xrf    = (xn + RND) >>> 16;
  assign yrf    = (yn + RND) >>> 16;
  assign xr     = RW'(xrf);
  assign yr     = RW'(yrf);
  assign px_off = PW'(xr) + PW'(cfg.mount_x);
  assign py_off = PW'(yr) + PW'(cfg.mount_y);

  assign ddx   = DW'(px) - DW'(cfg.mask_cx);
  assign ddy   = DW'(py) - DW'(cfg.mask_cy);
  assign sqx_c = QW'(ddx) * QW'(ddx);
  assign sqy_c = QW'(ddy) * QW'(ddy);

  assign dist_sq  = SW'(sqx) + SW'(sqy);
  assign keep     = ~(dist_sq < SW'(rsq));
  assign out_free = ~out_valid | points.ready;

  assign pxe = EW'(px);
  assign pye = EW'(py);
  assign pxs = (pxe > OMAX) ? OMAX : ((pxe < OMIN) ? OMIN : pxe);
  assign pys = (pye > OMAX) ? OMAX : ((pye < OMIN) ? OMIN : pye);

  assign points.valid   = out_valid;
  assign points.point_x = out_x;
  assign points.point_y = out_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      iter      <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_TEST) && keep && out_free) begin
        out_valid <= 1'b1;
      end else if (points.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            r_reg   <= q_data[RANGE_BITS+ANGLE_BITS-1:ANGLE_BITS];
            ang_reg <= q_data[ANGLE_BITS-1:0];
            state   <= S_MUL;
          end
        end
        S_MUL: begin
          x     <= signed'(XW'(prod));
          y     <= '0;
          z     <= z_fold;
          flip  <= flip_c;
          iter  <= '0;
          state <= S_ITER;
        end
        S_ITER: begin
          if (z >= 0) begin
            x <= x - sy;
            y <= y + sx;
            z <= z - atan;
          end else begin
            x <= x + sy;
            y <= y - sx;
            z <= z + atan;
          end
          iter <= iter + IW'(1);
          if (iter == IW'(lstp_pkg::CORDIC_STEPS - 1)) state <= S_OFFS;
        end
        S_OFFS: begin
          px    <= cfg.mirror_x ? -px_off : px_off;
          py    <= py_off;
          state <= S_SQR;
        end
        S_SQR: begin
          sqx   <= unsigned'(sqx_c);
          sqy   <= unsigned'(sqy_c);
          rsq   <= 32'(cfg.mask_radius) * 32'(cfg.mask_radius);
          state <= S_TEST;
        end
        S_TEST: begin
          if (!keep) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_x     <= OW'(pxs);
            out_y     <= OW'(pys);
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/lstp_checker.sv
module lstp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_ok,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [lstp_pkg::OUT_W-1:0]    out_x,
  input logic [lstp_pkg::OUT_W-1:0]    out_y
);

  // upper bound on points still owed: valid samples in, minus points out
  logic [31:0] pending;
  logic        in_take;
  logic        out_take;

  assign in_take  = in_valid & in_ready & in_ok;
  assign out_take = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      case ({in_take, out_take})
        2'b10:   pending <= (pending == '1) ? pending : pending + 32'd1;
        2'b01:   pending <= (pending == '0) ? pending : pending - 32'd1;
        default: pending <= pending;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y))
    else $error("stalled point changed or dropped");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    pending == 32'd0 |-> !out_valid)
    else $error("point shown with no valid sample outstanding");

  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    in_take && pending == 32'd0 |=> !out_valid ##1 !out_valid)
    else $error("point appeared faster than the conversion allows");

  a_skip_no_point: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_ok && pending == 32'd0 |=> !out_valid)
    else $error("skipped sample produced a point");

endmodule

bind lidar_scan_to_points_mask lstp_checker u_lstp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .in_ok     (samples.range_ok),
  .out_valid (points.valid),
  .out_ready (points.ready),
  .out_x     (points.point_x),
  .out_y     (points.point_y)
);
